// ===== hdl/vdist_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdist_pkg - shared types and constants of the vector distance unit
// Widths of the element, accumulator and result paths, sequencer states and
// the control group from the sequencer to the difference and square stage.
// ----------------------------------------------------------------------------
package vdist_pkg;

   localparam int ELEM_WIDTH = 16;
   localparam int ACC_WIDTH  = 46;
   localparam int DIST_WIDTH = 28;

   localparam int DIFF_WIDTH = ELEM_WIDTH + 1;
   localparam int MAG_WIDTH  = DIFF_WIDTH;
   localparam int TERM_WIDTH = 2 * MAG_WIDTH;
   localparam int SUM_WIDTH  = ((ACC_WIDTH > TERM_WIDTH) ? ACC_WIDTH : TERM_WIDTH) + 1;
   localparam int ROOT_WIDTH = (ACC_WIDTH + 1) / 2;
   localparam int XPAD_WIDTH = 2 * ROOT_WIDTH;
   localparam int REM_WIDTH  = ROOT_WIDTH + 2;
   localparam int CNT_WIDTH  = $clog2(ROOT_WIDTH + 1);
   localparam int WIDE_WIDTH = ((ACC_WIDTH > DIST_WIDTH) ? ACC_WIDTH : DIST_WIDTH) + 1;

   localparam logic MODE_L1 = 1'b0;
   localparam logic MODE_L2 = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAG,
      ST_SQR,
      ST_ACC,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_FIN,
      ST_RESP
   } vdist_state_type;

   typedef struct packed {
      logic load;
      logic mag_en;
      logic sq_en;
      logic mode;
   } term_ctrl_type;

endpackage
`default_nettype wire

// ===== hdl/vdist_term.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdist_term - difference, magnitude and square of one element pair
// Holds the pair, forms |a - b| in one step and the term (magnitude or its
// square) in the next, each step registered.
// ----------------------------------------------------------------------------
module vdist_term
   import vdist_pkg::*;
(
   input  wire logic                         clock,
   input  wire term_ctrl_type                ctrl,
   input  wire logic signed [ELEM_WIDTH-1:0] elem_a,
   input  wire logic signed [ELEM_WIDTH-1:0] elem_b,
   output logic             [TERM_WIDTH-1:0] term
);

   logic signed [ELEM_WIDTH-1:0] a_ff, b_ff;
   logic        [MAG_WIDTH-1:0]  mag_ff, mag_in;
   logic        [TERM_WIDTH-1:0] term_ff, term_in;
   logic signed [DIFF_WIDTH-1:0] diff;

   always_comb begin
      diff   = DIFF_WIDTH'(a_ff) - DIFF_WIDTH'(b_ff);
      mag_in = diff[DIFF_WIDTH-1] ? MAG_WIDTH'(-diff) : MAG_WIDTH'(diff);
      if (ctrl.mode == MODE_L2) begin
         term_in = TERM_WIDTH'(mag_ff) * TERM_WIDTH'(mag_ff);
      end else begin
         term_in = TERM_WIDTH'(mag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         a_ff <= elem_a;
         b_ff <= elem_b;
      end
      if (ctrl.mag_en) begin
         mag_ff <= mag_in;
      end
      if (ctrl.sq_en) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule
`default_nettype wire

// ===== hdl/vdist_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdist_sqrt - iterative integer square root
// Digit-by-digit method: one compare and subtract per cycle, one root bit per
// cycle, floor of the square root once busy falls.
// ----------------------------------------------------------------------------
module vdist_sqrt
   import vdist_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [ACC_WIDTH-1:0]  radicand,
   output logic                       busy,
   output logic      [ROOT_WIDTH-1:0] root
);

   logic                  busy_ff, busy_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [XPAD_WIDTH-1:0] x_ff, x_in;
   logic [REM_WIDTH-1:0]  rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0] root_ff, root_in;
   logic [REM_WIDTH-1:0]  rem_shift, trial;

   always_comb begin
      rem_shift = {rem_ff[REM_WIDTH-3:0], x_ff[XPAD_WIDTH-1 -: 2]};
      trial     = {root_ff, 2'b01};
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(ROOT_WIDTH);
         x_in    = XPAD_WIDTH'(radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in   = x_ff << 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
         end
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== hdl/vector_distance_l1_l2_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector_distance_l1_l2_unit - L1 / L2 distance of two Q8.8 vectors
// Accumulates |a - b| or (a - b)^2 per element pair with saturation and, on
// the last pair, returns the sum (L1) or its integer square root (L2).
// ----------------------------------------------------------------------------
// One element pair is handled at a time: an item without the last mark passes
// hold, magnitude, term and accumulate before the next item is taken. A last
// item in L1 mode then passes a state that loads the result before it is
// offered. In L2 mode the root unit runs one bit per cycle, and the result is
// loaded once the root unit is done and is then offered. No new item is taken
// while a result waits on rsp_stall.
// ----------------------------------------------------------------------------
module vector_distance_l1_l2_unit
   import vdist_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic                         csr_wr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [ELEM_WIDTH-1:0] req_elem_a,
   input  wire logic signed [ELEM_WIDTH-1:0] req_elem_b,
   input  wire logic                         req_last_elem,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic             [DIST_WIDTH-1:0] rsp_distance,
   output logic                              rsp_overflow
);

   vdist_state_type       state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic                  item_mode_ff, item_mode_in;
   logic                  last_ff, last_in;
   logic [ACC_WIDTH-1:0]  sum_ff, sum_in;
   logic                  sat_ff, sat_in;
   logic [DIST_WIDTH-1:0] dist_ff, dist_in;
   logic                  ovf_ff, ovf_in;

   term_ctrl_type         term_ctrl;
   logic [TERM_WIDTH-1:0] term;
   logic                  root_start;
   logic                  root_busy;
   logic [ROOT_WIDTH-1:0] root;
   logic [SUM_WIDTH-1:0]  total;
   logic [WIDE_WIDTH-1:0] wide;
   logic                  clamp;

   vdist_term u_term (
      .clock  (clock),
      .ctrl   (term_ctrl),
      .elem_a (req_elem_a),
      .elem_b (req_elem_b),
      .term   (term)
   );

   vdist_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_ff),
      .busy     (root_busy),
      .root     (root)
   );

   always_comb begin
      total = SUM_WIDTH'(sum_ff) + SUM_WIDTH'(term);
      wide  = (item_mode_ff == MODE_L2) ? WIDE_WIDTH'(root) : WIDE_WIDTH'(sum_ff);
      clamp = (wide[WIDE_WIDTH-1:DIST_WIDTH] != '0);
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = csr_wr_en ? csr_wr_data : mode_ff;
      item_mode_in   = item_mode_ff;
      last_in        = last_ff;
      sum_in         = sum_ff;
      sat_in         = sat_ff;
      dist_in        = dist_ff;
      ovf_in         = ovf_ff;
      term_ctrl      = '0;
      term_ctrl.mode = item_mode_ff;
      root_start     = 1'b0;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               term_ctrl.load = 1'b1;
               item_mode_in   = mode_ff;
               last_in        = req_last_elem;
               state_in       = ST_MAG;
            end
         end
         ST_MAG: begin
            term_ctrl.mag_en = 1'b1;
            state_in         = ST_SQR;
         end
         ST_SQR: begin
            term_ctrl.sq_en = 1'b1;
            state_in        = ST_ACC;
         end
         ST_ACC: begin
            if (total[SUM_WIDTH-1:ACC_WIDTH] != '0) begin
               sum_in = '1;
               sat_in = 1'b1;
            end else begin
               sum_in = total[ACC_WIDTH-1:0];
            end
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (item_mode_ff == MODE_L2) begin
               state_in = ST_ROOT_GO;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (!root_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            dist_in  = clamp ? '1 : wide[DIST_WIDTH-1:0];
            ovf_in   = sat_ff | clamp;
            sum_in   = '0;
            sat_in   = 1'b0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_L2;
         sum_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         sum_ff   <= sum_in;
         sat_ff   <= sat_in;
      end
      item_mode_ff <= item_mode_in;
      last_ff      <= last_in;
      dist_ff      <= dist_in;
      ovf_ff       <= ovf_in;
   end

   assign rsp_distance = dist_ff;
   assign rsp_overflow = ovf_ff;

`ifndef ASSERT_OFF
   a_no_take_while_resp: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("input taken while a result is pending");

   a_root_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      root_busy |-> (state_ff == ST_ROOT_WAIT))
      else $error("root unit busy outside its wait state");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> (sum_ff == '0) && !sat_ff)
      else $error("sum not cleared after the last item");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MAG))
      else $error("accepted item not processed");
`endif

endmodule
`default_nettype wire
